// ===== hw/rtl/swpb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spare worker pool balancer package
// Shared constants, codes and control structures for the balancer.
// ----------------------------------------------------------------------------
package swpb_pkg;

    localparam int SLOTS_DEF   = 32;
    localparam int CFG_W       = 6;
    localparam int IDX_IN_W    = 5;
    localparam int CNT_OUT_W   = 6;
    localparam int MAX_RESULTS = 32;
    localparam int NACT_W      = $clog2(MAX_RESULTS);
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic [CFG_W-1:0] MIN_SPARE_RST = 6'd5;
    localparam logic [CFG_W-1:0] MAX_SPARE_RST = 6'd10;
    localparam logic [CFG_W-1:0] MAX_TOTAL_RST = 6'd20;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        REG_MIN_SPARE = 2'd0,
        REG_MAX_SPARE = 2'd1,
        REG_MAX_TOTAL = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] min_spare;
        logic [CFG_W-1:0] max_spare;
        logic [CFG_W-1:0] max_total;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic apply;
        logic load;
        logic step;
        logic emit_none;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic start_mode;
        logic stop_mode;
        logic hit;
        logic act_last;
        logic at_end;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/swpb_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Balancer request channel
// Valid/ready channel carrying one status report or rebalance request.
// ----------------------------------------------------------------------------
interface swpb_req_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic [swpb_pkg::IDX_IN_W-1:0]    slot_index;
    logic                             now_busy;

    modport source (output valid, output req_type, output slot_index, output now_busy,
                    input ready);
    modport sink (input valid, input req_type, input slot_index, input now_busy,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/swpb_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Balancer result channel
// Valid/ready channel carrying one start, stop or no-change action.
// ----------------------------------------------------------------------------
interface swpb_rsp_if;
    logic                              valid;
    logic                              ready;
    swpb_pkg::action_t                 action;
    logic [swpb_pkg::IDX_IN_W-1:0]     action_slot;
    logic [swpb_pkg::CNT_OUT_W-1:0]    idle_after;
    logic [swpb_pkg::CNT_OUT_W-1:0]    busy_after;
    logic                              last;

    modport source (output valid, output action, output action_slot, output idle_after,
                    output busy_after, output last, input ready);
    modport sink (input valid, input action, input action_slot, input idle_after,
                  input busy_after, input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/swpb_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Balancer configuration registers
// APB-style register file holding the spare and total limits.
// ----------------------------------------------------------------------------
module swpb_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [swpb_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [swpb_pkg::PDATA_W-1:0]    pwdata,
    output logic      [swpb_pkg::PDATA_W-1:0]    prdata,
    output logic                                 pready,
    output swpb_pkg::cfg_t                       cfg
);

    swpb_pkg::cfg_t cfg_reg;
    swpb_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                swpb_pkg::REG_MIN_SPARE: cfg_next.min_spare = pwdata[swpb_pkg::CFG_W-1:0];
                swpb_pkg::REG_MAX_SPARE: cfg_next.max_spare = pwdata[swpb_pkg::CFG_W-1:0];
                swpb_pkg::REG_MAX_TOTAL: cfg_next.max_total = pwdata[swpb_pkg::CFG_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            swpb_pkg::REG_MIN_SPARE:
                prdata = swpb_pkg::PDATA_W'(cfg_reg.min_spare);
            swpb_pkg::REG_MAX_SPARE:
                prdata = swpb_pkg::PDATA_W'(cfg_reg.max_spare);
            swpb_pkg::REG_MAX_TOTAL:
                prdata = swpb_pkg::PDATA_W'(cfg_reg.max_total);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_spare <= swpb_pkg::MIN_SPARE_RST;
            cfg_reg.max_spare <= swpb_pkg::MAX_SPARE_RST;
            cfg_reg.max_total <= swpb_pkg::MAX_TOTAL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/swpb_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Balancer datapath
// Slot table, running idle and busy counts, slot scanner and result register.
// ----------------------------------------------------------------------------
module swpb_dp #(
    parameter int SLOTS = swpb_pkg::SLOTS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire swpb_pkg::cfg_t                   cfg,
    input  wire swpb_pkg::dp_cmd_t                cmd,
    output swpb_pkg::dp_stat_t                    stat,
    input  wire logic                             req_type,
    input  wire logic [swpb_pkg::IDX_IN_W-1:0]    slot_index,
    input  wire logic                             now_busy,
    swpb_rsp_if.source                            result
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CW    = ((CNT_W > swpb_pkg::CFG_W) ? CNT_W : swpb_pkg::CFG_W) + 1;
    localparam int OW    = swpb_pkg::CNT_OUT_W;

    logic [SLOTS-1:0]               in_use_reg, in_use_next;
    logic [SLOTS-1:0]               busy_reg, busy_next;
    logic [CNT_W-1:0]               idle_reg, idle_next;
    logic [CNT_W-1:0]               busy_tally_reg, busy_tally_next;
    logic [IDX_W-1:0]               scan_reg, scan_next;
    logic [CW-1:0]                  want_reg, want_next;
    logic [swpb_pkg::NACT_W-1:0]    nact_reg, nact_next;
    logic                           stop_mode_reg, stop_mode_next;
    logic                           out_valid_reg, out_valid_next;
    swpb_pkg::action_t              out_action_reg, out_action_next;
    logic [swpb_pkg::IDX_IN_W-1:0]  out_slot_reg, out_slot_next;
    logic [OW-1:0]                  out_idle_reg, out_idle_next;
    logic [OW-1:0]                  out_busy_reg, out_busy_next;
    logic                           out_last_reg, out_last_next;

    logic [IDX_W-1:0]  rep_idx;
    logic              rep_ok;
    logic [CW-1:0]     idle_e, busy_e, min_e, max_e, tot_e, limit_e, occ_e;
    logic [CW-1:0]     want_a, want_b, want_init, idle_dec;
    logic              cur_use, cur_busy, stop_more;

    function automatic logic [OW-1:0] sat_cnt(input logic [CW-1:0] v);
        logic [CW-1:0] top;
        top = CW'({OW{1'b1}});
        return (v > top) ? {OW{1'b1}} : v[OW-1:0];
    endfunction

    // A report counts only for a slot inside the table that holds a worker.
    assign rep_idx = IDX_W'(slot_index);
    assign rep_ok  = !req_type && (int'(slot_index) < SLOTS) && in_use_reg[rep_idx];

    assign idle_e  = CW'(idle_reg);
    assign busy_e  = CW'(busy_tally_reg);
    assign min_e   = CW'(cfg.min_spare);
    assign max_e   = CW'(cfg.max_spare);
    assign tot_e   = CW'(cfg.max_total);
    assign limit_e = (tot_e < CW'(SLOTS)) ? tot_e : CW'(SLOTS);
    assign occ_e   = idle_e + busy_e;

    assign want_a    = min_e - idle_e;
    assign want_b    = limit_e - occ_e;
    assign want_init = (want_b < want_a) ? want_b : want_a;

    assign cur_use   = in_use_reg[scan_reg];
    assign cur_busy  = busy_reg[scan_reg];
    assign idle_dec  = idle_e - CW'(1);
    assign stop_more = (idle_dec > max_e) && (idle_dec >= min_e);

    always_comb
    begin
        stat.start_mode = (idle_e < min_e) && (occ_e < limit_e);
        stat.stop_mode  = (idle_e > max_e) && (idle_e >= min_e);
        stat.hit        = stop_mode_reg ? (cur_use && !cur_busy) : !cur_use;
        stat.at_end     = (scan_reg == IDX_W'(SLOTS - 1));
        stat.act_last   = (stop_mode_reg ? !stop_more : (want_reg == CW'(1)))
                          || (nact_reg == swpb_pkg::NACT_W'(swpb_pkg::MAX_RESULTS - 1))
                          || stat.at_end;
        stat.out_free   = !out_valid_reg || result.ready;
    end

    always_comb
    begin
        in_use_next     = in_use_reg;
        busy_next       = busy_reg;
        idle_next       = idle_reg;
        busy_tally_next = busy_tally_reg;
        scan_next       = scan_reg;
        want_next       = want_reg;
        nact_next       = nact_reg;
        stop_mode_next  = stop_mode_reg;
        out_valid_next  = out_valid_reg;
        out_action_next = out_action_reg;
        out_slot_next   = out_slot_reg;
        out_idle_next   = out_idle_reg;
        out_busy_next   = out_busy_reg;
        out_last_next   = out_last_reg;

        if (cmd.apply && rep_ok)
        begin
            busy_next[rep_idx] = now_busy;
            if (busy_reg[rep_idx] != now_busy)
            begin
                if (now_busy)
                begin
                    idle_next       = idle_reg - CNT_W'(1);
                    busy_tally_next = busy_tally_reg + CNT_W'(1);
                end
                else
                begin
                    idle_next       = idle_reg + CNT_W'(1);
                    busy_tally_next = busy_tally_reg - CNT_W'(1);
                end
            end
        end

        if (cmd.load)
        begin
            scan_next      = '0;
            want_next      = want_init;
            nact_next      = '0;
            stop_mode_next = stat.stop_mode;
        end

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.emit_none)
        begin
            out_valid_next  = 1'b1;
            out_action_next = swpb_pkg::ACT_NONE;
            out_slot_next   = '0;
            out_idle_next   = sat_cnt(idle_e);
            out_busy_next   = sat_cnt(busy_e);
            out_last_next   = 1'b1;
        end

        if (cmd.step)
        begin
            if (stat.hit)
            begin
                in_use_next[scan_reg] = !stop_mode_reg;
                busy_next[scan_reg]   = 1'b0;
                out_valid_next        = 1'b1;
                out_slot_next         = swpb_pkg::IDX_IN_W'(scan_reg);
                out_busy_next         = sat_cnt(busy_e);
                out_last_next         = stat.act_last;
                nact_next             = nact_reg + swpb_pkg::NACT_W'(1);
                if (stop_mode_reg)
                begin
                    idle_next       = idle_reg - CNT_W'(1);
                    out_action_next = swpb_pkg::ACT_STOP;
                    out_idle_next   = sat_cnt(idle_dec);
                end
                else
                begin
                    idle_next       = idle_reg + CNT_W'(1);
                    want_next       = want_reg - CW'(1);
                    out_action_next = swpb_pkg::ACT_START;
                    out_idle_next   = sat_cnt(idle_e + CW'(1));
                end
            end
            if (!stat.at_end)
            begin
                scan_next = scan_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg     <= '0;
            busy_reg       <= '0;
            idle_reg       <= '0;
            busy_tally_reg <= '0;
            scan_reg       <= '0;
            want_reg       <= '0;
            nact_reg       <= '0;
            stop_mode_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_use_reg     <= in_use_next;
            busy_reg       <= busy_next;
            idle_reg       <= idle_next;
            busy_tally_reg <= busy_tally_next;
            scan_reg       <= scan_next;
            want_reg       <= want_next;
            nact_reg       <= nact_next;
            stop_mode_reg  <= stop_mode_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_action_reg <= out_action_next;
        out_slot_reg   <= out_slot_next;
        out_idle_reg   <= out_idle_next;
        out_busy_reg   <= out_busy_next;
        out_last_reg   <= out_last_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.action      = out_action_reg;
    assign result.action_slot = out_slot_reg;
    assign result.idle_after  = out_idle_reg;
    assign result.busy_after  = out_busy_reg;
    assign result.last        = out_last_reg;

    // The running counts can never exceed the number of slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        (CW'(idle_reg) + CW'(busy_tally_reg)) <= CW'(SLOTS))
        else $error("idle plus busy count exceeds the slot table");

    // A started slot is occupied on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && stat.hit && !stop_mode_reg) |=> in_use_reg[$past(scan_reg)])
        else $error("started slot is not marked in use");

    // A stop is only issued while an idle worker is counted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && stat.hit && stop_mode_reg) |-> (idle_reg != '0))
        else $error("stop issued with no idle worker counted");

endmodule
`default_nettype wire

// ===== hw/rtl/swpb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Balancer controller
// Sequences report, decision and slot scan, and paces results.
// ----------------------------------------------------------------------------
module swpb_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire swpb_pkg::dp_stat_t   stat,
    output swpb_pkg::dp_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.apply  = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (stat.start_mode || stat.stop_mode)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
                else if (stat.out_free)
                begin
                    cmd.emit_none = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (stat.out_free)
                begin
                    cmd.step = 1'b1;
                    if (stat.at_end || (stat.hit && stat.act_last))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // An accepted item always moves on to the decision step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DECIDE))
        else $error("accepted item did not reach the decision step");

    // The scan ends once the last slot has been examined.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && stat.at_end) |=> (state_reg == ST_IDLE))
        else $error("scan ran past the last slot");

endmodule
`default_nettype wire

// ===== hw/rtl/spare_worker_pool_balancer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Spare worker pool balancer
// Tracks worker slots as empty, idle or busy and starts or stops idle workers
// to keep the idle count between the spare limits.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Carries
//  request   in         valid / ready         req_type, slot_index, now_busy
//  result    out        valid / ready         action, action_slot, idle_after,
//                                             busy_after, last
//  apb       in         psel/penable/pready   min_spare, max_spare, max_total
//
// One item is taken per pass. The accept cycle applies the status report and
// the decision state then chooses between starting, stopping or doing
// nothing. A start or stop pass then walks the slot table one slot per cycle
// while the result register is free, using the single-slot scanner in the
// datapath. Idle and busy counts are kept as running counters, so no
// counting pass is needed. Reset empties every slot at once through
// per-slot flops; there is no clearing pass.
// A stalled result holds the scanner in place; the next item is taken while
// the final result of the previous one still waits in the output register.
//
module spare_worker_pool_balancer #(
    parameter int SLOTS = swpb_pkg::SLOTS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    swpb_req_if.sink                             request,
    swpb_rsp_if.source                           result,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [swpb_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [swpb_pkg::PDATA_W-1:0]    pwdata,
    output logic      [swpb_pkg::PDATA_W-1:0]    prdata,
    output logic                                 pready
);

    swpb_pkg::cfg_t      cfg;
    swpb_pkg::dp_cmd_t   cmd;
    swpb_pkg::dp_stat_t  stat;
    logic                in_ready;

    // The user must write limits only while the balancer is idle (the block does
    // not enforce this), so the datapath reads them directly.
    swpb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The controller owns the request handshake and paces the scanner
    // against the result register.
    swpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    assign request.ready = in_ready;

    // The datapath holds the slot table, the counters and the result
    // register that drives the result channel.
    swpb_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .stat       (stat),
        .req_type   (request.req_type),
        .slot_index (request.slot_index),
        .now_busy   (request.now_busy),
        .result     (result)
    );

endmodule
`default_nettype wire
